// ===== rtl/core/uart_tx_rx_ring_buffers_defines.svh =====
// Assertion macros for the UART ring buffer block.
// Included by the top level; no other dependencies.
`ifndef UART_TX_RX_RING_BUFFERS_DEFINES_SVH
`define UART_TX_RX_RING_BUFFERS_DEFINES_SVH
`ifndef SYNTH
`define UTRB_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define UTRB_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define UTRB_ASSERT_NOW(lbl, ante, cons, msg)
`define UTRB_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

// ===== rtl/core/utrb_pkg.sv =====
// Shared types and constants for the UART ring buffer block.
// No dependencies.
package utrb_pkg;

    typedef enum logic [1:0] {
        OP_DEVICE = 2'd0,
        OP_PUT    = 2'd1,
        OP_GET    = 2'd2,
        OP_CLEAR  = 2'd3
    } t_opcode;

    localparam int unsigned FILL_W = 7;

endpackage

// ===== rtl/core/uart_tx_rx_ring_buffers.sv =====
// Receive and transmit byte rings between a serial port and software.
// Depends on utrb_pkg and uart_tx_rx_ring_buffers_defines.svh.
//
//  channel  | handshake            | fields
//  ---------+----------------------+----------------------------------------------
//  command  | start, busy          | i_opcode i_rx_ready i_rx_byte i_tx_ready
//           |                      | i_put_byte
//  result   | o_valid (one cycle)  | o_tx_valid o_tx_byte o_get_valid o_get_byte
//           |                      | o_put_accepted o_rx_dropped o_tx_irq_enable
//           |                      | o_rx_fill o_tx_fill
//
// One command is taken every cycle and busy stays low. Each result is shown
// after its command passes the input register and then the ring update, whose
// single write port and registered read port per ring set that rate.
// Reset clears pointers, levels and the interrupt enable; ring contents are not
// cleared. The receiver cannot stall, so nothing ever holds a command off.
`include "uart_tx_rx_ring_buffers_defines.svh"

module uart_tx_rx_ring_buffers
    import utrb_pkg::*;
#(
    parameter int unsigned RX_DEPTH = 64,
    parameter int unsigned TX_DEPTH = 64
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  logic [1:0]        i_opcode,
    input  logic              i_rx_ready,
    input  logic [7:0]        i_rx_byte,
    input  logic              i_tx_ready,
    input  logic [7:0]        i_put_byte,
    output logic              o_valid,
    output logic              o_tx_valid,
    output logic [7:0]        o_tx_byte,
    output logic              o_get_valid,
    output logic [7:0]        o_get_byte,
    output logic              o_put_accepted,
    output logic              o_rx_dropped,
    output logic              o_tx_irq_enable,
    output logic [FILL_W-1:0] o_rx_fill,
    output logic [FILL_W-1:0] o_tx_fill
);

    localparam int unsigned RX_PW = (RX_DEPTH > 1) ? $clog2(RX_DEPTH) : 1;
    localparam int unsigned TX_PW = (TX_DEPTH > 1) ? $clog2(TX_DEPTH) : 1;
    localparam int unsigned RX_LW = $clog2(RX_DEPTH + 1);
    localparam int unsigned TX_LW = $clog2(TX_DEPTH + 1);

    logic [7:0] rx_mem [RX_DEPTH];
    logic [7:0] tx_mem [TX_DEPTH];

    logic       r_in_vld;
    t_opcode    r_opcode;
    logic       r_rx_ready;
    logic [7:0] r_rx_byte;
    logic       r_tx_ready;
    logic [7:0] r_put_byte;

    logic [RX_PW-1:0] r_rx_head, r_rx_tail, n_rx_head, n_rx_tail;
    logic [RX_LW-1:0] r_rx_level, n_rx_level;
    logic [TX_PW-1:0] r_tx_head, r_tx_tail, n_tx_head, n_tx_tail;
    logic [TX_LW-1:0] r_tx_level, n_tx_level;
    logic             r_tx_int_on, n_tx_int_on;

    logic       r_out_vld;
    logic       r_tx_valid, n_tx_valid;
    logic       r_get_valid, n_get_valid;
    logic       r_put_acc, n_put_acc;
    logic       r_drop, n_drop;
    logic       n_rx_wr, n_tx_wr;
    logic [7:0] r_rx_rdata, r_tx_rdata;

    logic rx_full, tx_full, rx_empty, tx_empty;

    assign busy     = 1'b0;
    assign rx_full  = (r_rx_level == RX_LW'(RX_DEPTH));
    assign tx_full  = (r_tx_level == TX_LW'(TX_DEPTH));
    assign rx_empty = (r_rx_level == '0);
    assign tx_empty = (r_tx_level == '0);

    always_comb begin
        n_rx_head   = r_rx_head;
        n_rx_tail   = r_rx_tail;
        n_rx_level  = r_rx_level;
        n_tx_head   = r_tx_head;
        n_tx_tail   = r_tx_tail;
        n_tx_level  = r_tx_level;
        n_tx_int_on = r_tx_int_on;
        n_tx_valid  = 1'b0;
        n_get_valid = 1'b0;
        n_put_acc   = 1'b0;
        n_drop      = 1'b0;
        n_rx_wr     = 1'b0;
        n_tx_wr     = 1'b0;
        if (r_in_vld) begin
            case (r_opcode)
                OP_DEVICE: begin
                    if (r_rx_ready) begin
                        if (!rx_full) begin
                            n_rx_wr    = 1'b1;
                            n_rx_head  = (r_rx_head == RX_PW'(RX_DEPTH - 1)) ?
                                         '0 : r_rx_head + RX_PW'(1);
                            n_rx_level = r_rx_level + RX_LW'(1);
                        end else begin
                            n_drop = 1'b1;
                        end
                    end
                    if (r_tx_ready) begin
                        if (!tx_empty) begin
                            n_tx_valid = 1'b1;
                            n_tx_tail  = (r_tx_tail == TX_PW'(TX_DEPTH - 1)) ?
                                         '0 : r_tx_tail + TX_PW'(1);
                            n_tx_level = r_tx_level - TX_LW'(1);
                        end else begin
                            n_tx_int_on = 1'b0;
                        end
                    end
                end
                OP_PUT: begin
                    if (!tx_full) begin
                        n_tx_wr     = 1'b1;
                        n_tx_head   = (r_tx_head == TX_PW'(TX_DEPTH - 1)) ?
                                      '0 : r_tx_head + TX_PW'(1);
                        n_tx_level  = r_tx_level + TX_LW'(1);
                        n_tx_int_on = 1'b1;
                        n_put_acc   = 1'b1;
                    end
                end
                OP_GET: begin
                    if (!rx_empty) begin
                        n_get_valid = 1'b1;
                        n_rx_tail   = (r_rx_tail == RX_PW'(RX_DEPTH - 1)) ?
                                      '0 : r_rx_tail + RX_PW'(1);
                        n_rx_level  = r_rx_level - RX_LW'(1);
                    end
                end
                OP_CLEAR: begin
                    n_rx_head  = '0;
                    n_rx_tail  = '0;
                    n_rx_level = '0;
                    n_tx_head  = '0;
                    n_tx_tail  = '0;
                    n_tx_level = '0;
                end
                default: begin
                    n_rx_head = r_rx_head;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        r_opcode   <= t_opcode'(i_opcode);
        r_rx_ready <= i_rx_ready;
        r_rx_byte  <= i_rx_byte;
        r_tx_ready <= i_tx_ready;
        r_put_byte <= i_put_byte;

        r_tx_valid  <= n_tx_valid;
        r_get_valid <= n_get_valid;
        r_put_acc   <= n_put_acc;
        r_drop      <= n_drop;

        if (!i_rst_n) begin
            r_in_vld    <= 1'b0;
            r_out_vld   <= 1'b0;
            r_rx_head   <= '0;
            r_rx_tail   <= '0;
            r_rx_level  <= '0;
            r_tx_head   <= '0;
            r_tx_tail   <= '0;
            r_tx_level  <= '0;
            r_tx_int_on <= 1'b0;
        end else begin
            r_in_vld    <= start && !busy;
            r_out_vld   <= r_in_vld;
            r_rx_head   <= n_rx_head;
            r_rx_tail   <= n_rx_tail;
            r_rx_level  <= n_rx_level;
            r_tx_head   <= n_tx_head;
            r_tx_tail   <= n_tx_tail;
            r_tx_level  <= n_tx_level;
            r_tx_int_on <= n_tx_int_on;
        end
    end

    always_ff @(posedge i_clk) begin
        if (n_rx_wr) begin
            rx_mem[r_rx_head] <= r_rx_byte;
        end
        r_rx_rdata <= rx_mem[r_rx_tail];
    end

    always_ff @(posedge i_clk) begin
        if (n_tx_wr) begin
            tx_mem[r_tx_head] <= r_put_byte;
        end
        r_tx_rdata <= tx_mem[r_tx_tail];
    end

    assign o_valid         = r_out_vld;
    assign o_tx_valid      = r_tx_valid;
    assign o_tx_byte       = r_tx_valid ? r_tx_rdata : 8'd0;
    assign o_get_valid     = r_get_valid;
    assign o_get_byte      = r_get_valid ? r_rx_rdata : 8'd0;
    assign o_put_accepted  = r_put_acc;
    assign o_rx_dropped    = r_drop;
    assign o_tx_irq_enable = r_tx_int_on;
    assign o_rx_fill       = FILL_W'(r_rx_level);
    assign o_tx_fill       = FILL_W'(r_tx_level);

    `UTRB_ASSERT_NEXT(a_result_follows, start && !busy, ##1 o_valid, "result beat missing")
    `UTRB_ASSERT_NOW(a_level_bound, 1'b1,
        r_rx_level <= RX_LW'(RX_DEPTH) && r_tx_level <= TX_LW'(TX_DEPTH), "ring level overflow")
    `UTRB_ASSERT_NOW(a_put_sets_irq, o_valid && o_put_accepted, o_tx_irq_enable,
        "accepted put left transmit interrupt disabled")
    `UTRB_ASSERT_NOW(a_drop_when_full, o_valid && o_rx_dropped, r_rx_level == RX_LW'(RX_DEPTH),
        "received byte dropped while ring had room")

endmodule
